>>> sv/hpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hpsd_pkg;

  // Segment and run sizing
  localparam int FFT_SIZE     = 128;
  localparam int HALF_BINS    = FFT_SIZE / 2;
  localparam int MAX_SEGMENTS = 1024;
  localparam int AW           = $clog2(FFT_SIZE);
  localparam int BW           = $clog2(HALF_BINS);
  localparam int CW           = $clog2(MAX_SEGMENTS + 1);
  // Per-bin dB sum: 16-bit bin values over up to MAX_SEGMENTS segments
  localparam int SW           = 16 + $clog2(MAX_SEGMENTS);
  localparam int DCW          = $clog2(SW + 1);
  // Power word and logarithm
  localparam int PW           = 46;
  localparam int LOG_FRAC     = 16;
  localparam int LCW          = $clog2(LOG_FRAC);

  localparam logic [14:0] DB_OFFSET_RESET = 15'd17626;
  // 10*log10(2) in Q16
  localparam logic [17:0] LOG10_2_Q16     = 18'd197283;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               end_of_data;
  } in_t;

  typedef struct packed {
    logic [5:0]         bin_index;
    logic signed [15:0] psd_db;
    logic               empty_run;
    logic               last_bin;
  } out_t;

  typedef logic signed [16:0] trig_t;
  typedef trig_t [FFT_SIZE-1:0] trig_rom_t;
  typedef logic [16:0] hann_t;
  typedef hann_t [FFT_SIZE-1:0] hann_rom_t;

  // Controller to datapath commands
  typedef struct packed {
    logic          win_mul;
    logic          win_wr;
    logic [AW-1:0] fill;
    logic          mac_clr;
    logic          mac_issue;
    logic [AW-1:0] k;
    logic [BW-1:0] bin;
    logic          rnd;
    logic          sq;
    logic          psum;
    logic          norm_shift;
    logic          log_load;
    logic          log_step;
    logic          lmul;
    logic          db;
    logic          sum_rd;
    logic          sum_wr;
    logic          first;
    logic          div_start;
    logic          out_load;
    logic          no_seg;
    logic          last_bin;
    logic [CW-1:0] seg_count;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;
    logic p_zero;
    logic p_top;
    logic div_done;
  } status_t;

  // Sine of t/2^24 turns at scale 2^15, odd polynomial on the first quadrant
  function automatic trig_t sine_turn(input longint unsigned t);
    longint unsigned q, r, x, x2, s, v;
    q = (t >> 22) & 64'd3;
    r = t & 64'h3FFFFF;
    if (q[0]) r = 64'h400000 - r;
    x  = r << 8;
    x2 = (x * x) >> 30;
    s  = 64'd172272;
    s  = 64'd5026995 - ((s * x2) >> 30);
    s  = 64'd85569306 - ((s * x2) >> 30);
    s  = 64'd693598668 - ((s * x2) >> 30);
    s  = 64'd1686629713 - ((s * x2) >> 30);
    v  = (s * x) >> 30;
    v  = (v + 64'd16384) >> 15;
    if (v > 64'd32768) v = 64'd32768;
    return (q >= 64'd2) ? -trig_t'(v) : trig_t'(v);
  endfunction

  function automatic trig_rom_t make_trig(input bit cosine);
    trig_rom_t rom;
    longint unsigned t;
    for (int p = 0; p < FFT_SIZE; p++) begin
      t = ((longint'(p) << 24) + FFT_SIZE / 2) / FFT_SIZE;
      rom[p] = cosine ? sine_turn((t + 64'h400000) & 64'hFFFFFF) : sine_turn(t);
    end
    return rom;
  endfunction

  function automatic hann_rom_t make_hann(input trig_rom_t cosr);
    hann_rom_t rom;
    int c;
    for (int p = 0; p < FFT_SIZE; p++) begin
      c = int'(cosr[p]);
      rom[p] = hann_t'((32769 - c) >> 1);
    end
    return rom;
  endfunction

  localparam trig_rom_t COS_ROM  = make_trig(1'b1);
  localparam trig_rom_t SIN_ROM  = make_trig(1'b0);
  localparam hann_rom_t HANN_ROM = make_hann(COS_ROM);

endpackage
`default_nettype wire

>>> sv/hpsd_div.sv
`timescale 1ns / 1ps
`default_nettype none
module hpsd_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [hpsd_pkg::SW-1:0]  dividend,
  input  wire logic [hpsd_pkg::CW-1:0]  divisor,
  output logic                          done,
  output logic [hpsd_pkg::SW-1:0]       quotient
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [hpsd_pkg::DCW-1:0]    cnt_r, cnt_nxt;
  logic [hpsd_pkg::CW-1:0]     rem_r, rem_nxt;
  logic [hpsd_pkg::SW-1:0]     quo_r, quo_nxt;
  logic [hpsd_pkg::CW-1:0]     dsr_r, dsr_nxt;
  logic [hpsd_pkg::CW:0]       rem_sh;
  logic [hpsd_pkg::CW:0]       diff;
  logic                        ge;

  // One restoring step a cycle, quotient bits shift in from the right
  always_comb begin
    rem_sh   = {rem_r, quo_r[hpsd_pkg::SW-1]};
    diff     = rem_sh - {1'b0, dsr_r};
    ge       = (rem_sh >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[hpsd_pkg::CW-1:0] : rem_sh[hpsd_pkg::CW-1:0];
      quo_nxt = {quo_r[hpsd_pkg::SW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == hpsd_pkg::DCW'(hpsd_pkg::SW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> sv/hpsd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module hpsd_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [14:0]      cfg_data,
  input  wire hpsd_pkg::in_t    in_data,
  input  wire hpsd_pkg::cmd_t   cmd,
  output hpsd_pkg::status_t     status,
  output hpsd_pkg::out_t        out_data
);

  // Configuration
  logic [14:0] db_offset_r;

  // Window and segment store
  logic signed [33:0] win_prod_r;
  logic signed [15:0] buf_mem [hpsd_pkg::FFT_SIZE];
  logic        [33:0] win_mag;
  logic        [33:0] win_q;
  logic signed [16:0] win_res;

  // Complex MAC
  logic [hpsd_pkg::AW-1:0] ph_r;
  logic signed [15:0] buf_rd_r;
  logic signed [16:0] cos_r, sin_r;
  logic               v1_r, v2_r;
  logic signed [32:0] prod_re_r, prod_im_r;
  logic signed [39:0] acc_re_r, acc_im_r;

  // Power and logarithm
  logic signed [23:0] re15_r, im15_r;
  logic [hpsd_pkg::PW-2:0] sq_re_r, sq_im_r;
  logic [hpsd_pkg::PW-1:0] p_r;
  logic [5:0]              exp_r;
  logic [30:0]             m_r;
  logic [61:0]             m_sq;
  logic [31:0]             m_t;
  logic [hpsd_pkg::LOG_FRAC-1:0] frac_r;
  logic signed [6:0]       em30;
  logic signed [21:0]      log2_l;
  logic signed [40:0]      lprod_r;
  logic [40:0]             l_mag;
  logic [40:0]             l_q;
  logic signed [17:0]      db_rnd;
  logic signed [17:0]      db_sub;
  logic signed [15:0]      db_sat;
  logic signed [15:0]      db_r;

  // Sums and averaging
  logic signed [hpsd_pkg::SW-1:0] sum_mem [hpsd_pkg::HALF_BINS];
  logic signed [hpsd_pkg::SW-1:0] sum_rd_r;
  logic        [hpsd_pkg::SW-1:0] sum_mag;
  logic        [hpsd_pkg::SW-1:0] div_dividend;
  logic        [hpsd_pkg::SW-1:0] div_q;
  logic        [hpsd_pkg::SW-1:0] avg;
  logic                           div_done;
  logic                           sum_neg_r;
  hpsd_pkg::out_t                 out_r;

  // Round by 2^15, ties away from zero
  function automatic logic signed [23:0] rnd_acc(input logic signed [39:0] v);
    logic [39:0] mag;
    logic [39:0] q;
    mag = v[39] ? 40'(-v) : 40'(v);
    q   = (mag + 40'd16384) >> 15;
    return v[39] ? -$signed(q[23:0]) : $signed(q[23:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_offset_r <= hpsd_pkg::DB_OFFSET_RESET;
    end else if (cfg_we) begin
      db_offset_r <= cfg_data;
    end
  end

  // Window each sample on arrival, store the windowed value
  always_comb begin
    win_mag = win_prod_r[33] ? 34'(-win_prod_r) : 34'(win_prod_r);
    win_q   = (win_mag + 34'd16384) >> 15;
    win_res = win_prod_r[33] ? -$signed(win_q[16:0]) : $signed(win_q[16:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.win_mul) begin
      win_prod_r <= in_data.sample * $signed({1'b0, hpsd_pkg::HANN_ROM[cmd.fill]});
    end
    if (cmd.win_wr) begin
      buf_mem[cmd.fill] <= win_res[15:0];
    end
  end

  // Fetch sample and twiddles, multiply, accumulate
  always_ff @(posedge clk) begin
    if (cmd.mac_issue) begin
      buf_rd_r <= buf_mem[cmd.k];
      cos_r    <= hpsd_pkg::COS_ROM[ph_r];
      sin_r    <= hpsd_pkg::SIN_ROM[ph_r];
    end
    if (cmd.mac_clr) begin
      ph_r <= '0;
    end else if (cmd.mac_issue) begin
      ph_r <= ph_r + hpsd_pkg::AW'(cmd.bin);
    end
    if (v1_r) begin
      prod_re_r <= buf_rd_r * cos_r;
      prod_im_r <= buf_rd_r * sin_r;
    end
    if (cmd.mac_clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v2_r) begin
      acc_re_r <= acc_re_r + 40'(prod_re_r);
      acc_im_r <= acc_im_r - 40'(prod_im_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
    end
  end

  // Logarithm helpers
  always_comb begin
    m_sq   = m_r * m_r;
    m_t    = m_sq[61:30];
    em30   = $signed({1'b0, exp_r}) - 7'sd30;
    log2_l = $signed({em30[5:0], frac_r});
    l_mag  = lprod_r[40] ? 41'(-lprod_r) : 41'(lprod_r);
    l_q    = (l_mag + 41'd8388608) >> 24;
    db_rnd = lprod_r[40] ? -$signed(l_q[17:0]) : $signed(l_q[17:0]);
    db_sub = db_rnd - $signed({3'b000, db_offset_r});
    if (db_sub < -18'sd32768) begin
      db_sat = 16'sh8000;
    end else if (db_sub > 18'sd32767) begin
      db_sat = 16'sh7FFF;
    end else begin
      db_sat = db_sub[15:0];
    end
  end

  // Round, square, normalise, take log2 and scale to dB
  always_ff @(posedge clk) begin
    if (cmd.rnd) begin
      re15_r <= rnd_acc(acc_re_r);
      im15_r <= rnd_acc(acc_im_r);
    end
    if (cmd.sq) begin
      sq_re_r <= (hpsd_pkg::PW - 1)'(re15_r * re15_r);
      sq_im_r <= (hpsd_pkg::PW - 1)'(im15_r * im15_r);
    end
    if (cmd.psum) begin
      p_r   <= {1'b0, sq_re_r} + {1'b0, sq_im_r};
      exp_r <= 6'(hpsd_pkg::PW - 1);
    end else if (cmd.norm_shift) begin
      p_r   <= p_r << 1;
      exp_r <= exp_r - 1'b1;
    end
    if (cmd.log_load) begin
      m_r    <= p_r[hpsd_pkg::PW-1 -: 31];
      frac_r <= '0;
    end else if (cmd.log_step) begin
      m_r    <= m_t[31] ? m_t[31:1] : m_t[30:0];
      frac_r <= {frac_r[hpsd_pkg::LOG_FRAC-2:0], m_t[31]};
    end
    if (cmd.lmul) begin
      lprod_r <= log2_l * $signed({1'b0, hpsd_pkg::LOG10_2_Q16});
    end
    if (cmd.db) begin
      db_r <= (p_r == '0) ? 16'sh8000 : db_sat;
    end
  end

  // Per-bin sum memory: first segment of a run overwrites
  always_ff @(posedge clk) begin
    if (cmd.sum_rd) begin
      sum_rd_r <= sum_mem[cmd.bin];
    end
    if (cmd.sum_wr) begin
      sum_mem[cmd.bin] <= cmd.first ? hpsd_pkg::SW'(db_r) : sum_rd_r + hpsd_pkg::SW'(db_r);
    end
  end

  // Average: magnitude plus half the count, divided, sign restored
  always_comb begin
    sum_mag      = sum_rd_r[hpsd_pkg::SW-1] ? hpsd_pkg::SW'(-sum_rd_r)
                                            : hpsd_pkg::SW'(sum_rd_r);
    div_dividend = sum_mag + hpsd_pkg::SW'(cmd.seg_count >> 1);
    avg          = sum_neg_r ? -div_q : div_q;
  end

  hpsd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (cmd.seg_count),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sum_neg_r <= sum_rd_r[hpsd_pkg::SW-1];
    end
    if (cmd.out_load) begin
      out_r.bin_index <= cmd.bin;
      out_r.psd_db    <= cmd.no_seg ? 16'sd0 : $signed(avg[15:0]);
      out_r.empty_run <= cmd.no_seg;
      out_r.last_bin  <= cmd.last_bin;
    end
  end

  always_comb begin
    status.pipe_busy = v1_r | v2_r;
    status.p_zero    = (p_r == '0);
    status.p_top     = p_r[hpsd_pkg::PW-1];
    status.div_done  = div_done;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

>>> sv/hpsd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module hpsd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  input  wire logic               out_stall,
  input  wire hpsd_pkg::status_t  status,
  output logic                    in_stall,
  output logic                    out_valid,
  output hpsd_pkg::cmd_t          cmd
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'd1 << 0,
    S_WIN   = 19'd1 << 1,
    S_MCLR  = 19'd1 << 2,
    S_MAC   = 19'd1 << 3,
    S_DRAIN = 19'd1 << 4,
    S_RND   = 19'd1 << 5,
    S_SQ    = 19'd1 << 6,
    S_PSUM  = 19'd1 << 7,
    S_NORM  = 19'd1 << 8,
    S_LOG   = 19'd1 << 9,
    S_LMUL  = 19'd1 << 10,
    S_DB    = 19'd1 << 11,
    S_ACCRD = 19'd1 << 12,
    S_ACCWR = 19'd1 << 13,
    S_EMPTY = 19'd1 << 14,
    S_ERD   = 19'd1 << 15,
    S_EDIV  = 19'd1 << 16,
    S_EWAIT = 19'd1 << 17,
    S_EOUT  = 19'd1 << 18
  } state_t;

  state_t                   state_r, state_nxt;
  logic [hpsd_pkg::AW-1:0]  fill_r, fill_nxt;
  logic [hpsd_pkg::AW-1:0]  k_r, k_nxt;
  logic [hpsd_pkg::BW-1:0]  bin_r, bin_nxt;
  logic [hpsd_pkg::LCW-1:0] lc_r, lc_nxt;
  logic [hpsd_pkg::CW-1:0]  seg_r, seg_nxt;
  logic                     last_r, last_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     slot_free;
  logic                     is_last_bin;

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    k_nxt       = k_r;
    bin_nxt     = bin_r;
    lc_nxt      = lc_r;
    seg_nxt     = seg_r;
    last_nxt    = last_r;
    slot_free   = !out_valid_r || !out_stall;
    is_last_bin = (bin_r == hpsd_pkg::BW'(hpsd_pkg::HALF_BINS - 1));
    cmd           = '0;
    cmd.fill      = fill_r;
    cmd.k         = k_r;
    cmd.bin       = bin_r;
    cmd.seg_count = seg_r;
    cmd.first     = (seg_r == '0);
    cmd.last_bin  = is_last_bin;
    case (state_r)
      // Take a sample and start its window product
      S_IDLE: begin
        if (in_valid) begin
          cmd.win_mul = 1'b1;
          last_nxt    = in_last;
          state_nxt   = S_WIN;
        end
      end
      // Store the windowed sample, then decide what the segment needs
      S_WIN: begin
        cmd.win_wr = 1'b1;
        bin_nxt    = '0;
        if (fill_r == hpsd_pkg::AW'(hpsd_pkg::FFT_SIZE - 1)) begin
          fill_nxt = '0;
          if (seg_r < hpsd_pkg::CW'(hpsd_pkg::MAX_SEGMENTS)) begin
            state_nxt = S_MCLR;
          end else if (last_r) begin
            state_nxt = S_ERD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (last_r) begin
          // drop the partial segment
          fill_nxt  = '0;
          state_nxt = (seg_r == '0) ? S_EMPTY : S_ERD;
        end else begin
          fill_nxt  = fill_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MCLR: begin
        cmd.mac_clr = 1'b1;
        k_nxt       = '0;
        state_nxt   = S_MAC;
      end
      // Stream one segment through the MAC for this bin
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        k_nxt         = k_r + 1'b1;
        if (k_r == hpsd_pkg::AW'(hpsd_pkg::FFT_SIZE - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_PSUM;
      end
      S_PSUM: begin
        cmd.psum  = 1'b1;
        state_nxt = S_NORM;
      end
      // Shift the power left until its top bit is set; a zero power goes straight to dB
      S_NORM: begin
        if (status.p_zero) begin
          state_nxt = S_DB;
        end else if (status.p_top) begin
          cmd.log_load = 1'b1;
          lc_nxt       = '0;
          state_nxt    = S_LOG;
        end else begin
          cmd.norm_shift = 1'b1;
        end
      end
      // One fraction bit of log2 per squaring
      S_LOG: begin
        cmd.log_step = 1'b1;
        lc_nxt       = lc_r + 1'b1;
        if (lc_r == hpsd_pkg::LCW'(hpsd_pkg::LOG_FRAC - 1)) begin
          state_nxt = S_LMUL;
        end
      end
      S_LMUL: begin
        cmd.lmul  = 1'b1;
        state_nxt = S_DB;
      end
      S_DB: begin
        cmd.db    = 1'b1;
        state_nxt = S_ACCRD;
      end
      S_ACCRD: begin
        cmd.sum_rd = 1'b1;
        state_nxt  = S_ACCWR;
      end
      // Add into the bin sum, advance to the next bin or close the segment
      S_ACCWR: begin
        cmd.sum_wr = 1'b1;
        if (is_last_bin) begin
          seg_nxt   = seg_r + 1'b1;
          bin_nxt   = '0;
          state_nxt = last_r ? S_ERD : S_IDLE;
        end else begin
          bin_nxt   = bin_r + 1'b1;
          state_nxt = S_MCLR;
        end
      end
      // No complete segment: one flagged result
      S_EMPTY: begin
        cmd.no_seg   = 1'b1;
        cmd.last_bin = 1'b1;
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_ERD: begin
        cmd.sum_rd = 1'b1;
        state_nxt  = S_EDIV;
      end
      S_EDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_EWAIT;
      end
      S_EWAIT: begin
        if (status.div_done) begin
          state_nxt = S_EOUT;
        end
      end
      // Hand the average to the output register once it is free
      S_EOUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          if (is_last_bin) begin
            seg_nxt   = '0;
            bin_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            bin_nxt   = bin_r + 1'b1;
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      k_r         <= '0;
      bin_r       <= '0;
      lc_r        <= '0;
      seg_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      bin_r       <= bin_nxt;
      lc_r        <= lc_nxt;
      seg_r       <= seg_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> sv/hann_window_psd_estimator_core.sv
// Intake: each sample is windowed (product, then store).
// A sample that completes one of the first MAX_SEGMENTS segments then holds the input
// for one pass per kept bin: the shared complex MAC, then round, square, normalising
// shifts, log2 squarings, dB and sum. On end of data each average comes from the
// serial divider.
// Reset (rst_n low, synchronous) clears control state and loads db_offset 17626.
`timescale 1ns / 1ps
`default_nettype none
module hann_window_psd_estimator_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire hpsd_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output hpsd_pkg::out_t       out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [14:0]     cfg_data
);

  hpsd_pkg::cmd_t    cmd;
  hpsd_pkg::status_t status;

  // Register writes are taken at once
  assign cfg_ready = 1'b1;

  hpsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.end_of_data),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  hpsd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  // Output register is reloaded only when empty or being taken
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending request");

  // A sample is accepted only while the MAC pipeline is quiet
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (!cmd.mac_issue && !status.pipe_busy))
    else $error("sample accepted during a DFT pass");

  // The divider never finishes in the cycle after it starts
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !status.div_done)
    else $error("divider done too early");

endmodule
`default_nettype wire

>>> tb/sv/hann_window_psd_checker.sv
`timescale 1ns / 1ps
module hann_window_psd_checker
  import hpsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [14:0] cfg_data,
  output int   errors,
  output int   pending
);

  int cos_tab [FFT_SIZE];
  int sin_tab [FFT_SIZE];
  int hann_tab [FFT_SIZE];
  int seg_samples [FFT_SIZE];
  int db_sums [HALF_BINS];
  int seg_total;
  int fill_pos;
  logic [14:0] offset_db;
  out_t psd_queue [$];

  // Round to nearest, ties away from zero
  function automatic longint rnd_shift(input longint v, input int s);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-(v + 1)) + 1 : v;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // Sine of t/2^24 turns at scale 2^15
  function automatic int turn_sine(input longint unsigned t);
    longint unsigned quad, r, x, x2, acc, v;
    quad = (t >> 22) & 3;
    r = t & 64'h3FFFFF;
    if (quad[0]) r = 64'h400000 - r;
    x = r << 8;
    x2 = (x * x) >> 30;
    acc = 172272;
    acc = 5026995 - ((acc * x2) >> 30);
    acc = 85569306 - ((acc * x2) >> 30);
    acc = 693598668 - ((acc * x2) >> 30);
    acc = 1686629713 - ((acc * x2) >> 30);
    v = (acc * x) >> 30;
    v = (v + 16384) >> 15;
    if (v > 32768) v = 32768;
    return (quad >= 2) ? -int'(v) : int'(v);
  endfunction

  // 10*log10(p / 2^30) in Q8.8
  function automatic longint power_to_db(input longint unsigned p);
    int e;
    longint unsigned m;
    longint frac, l;
    e = 63;
    frac = 0;
    while (p[e] == 1'b0) e--;
    m = (e > 30) ? (p >> (e - 30)) : (p << (30 - e));
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (longint'(1) << i);
      end
    end
    l = longint'(e - 30) * 65536 + frac;
    return rnd_shift(l * 197283, 24);
  endfunction

  // Window, transform and accumulate one full segment
  function automatic void fold_segment();
    int w [FFT_SIZE];
    longint re, im, r15, i15, db;
    longint unsigned p;
    for (int k = 0; k < FFT_SIZE; k++)
      w[k] = int'(rnd_shift(longint'(seg_samples[k]) * hann_tab[k], 15));
    for (int b = 0; b < HALF_BINS; b++) begin
      re = 0;
      im = 0;
      for (int k = 0; k < FFT_SIZE; k++) begin
        re += longint'(w[k]) * cos_tab[(k * b) % FFT_SIZE];
        im -= longint'(w[k]) * sin_tab[(k * b) % FFT_SIZE];
      end
      r15 = rnd_shift(re, 15);
      i15 = rnd_shift(im, 15);
      p = longint'(r15 * r15) + longint'(i15 * i15);
      if (p == 0) begin
        db = -32768;
      end else begin
        db = power_to_db(p) - longint'(offset_db);
        if (db < -32768) db = -32768;
        if (db > 32767) db = 32767;
      end
      db_sums[b] += int'(db);
    end
  endfunction

  // Take one sample; on end of data queue the averaged spectrum, or one flagged empty result
  function automatic void take_sample(input in_t req);
    out_t r;
    longint sum;
    longint unsigned mag;
    if (fill_pos >= FFT_SIZE) fill_pos = 0;
    seg_samples[fill_pos] = int'(req.sample);
    fill_pos++;
    if (fill_pos >= FFT_SIZE) begin
      fill_pos = 0;
      if (seg_total < MAX_SEGMENTS) begin
        fold_segment();
        seg_total++;
      end
    end
    if (!req.end_of_data) return;
    if (seg_total == 0) begin
      r = '0;
      r.empty_run = 1'b1;
      r.last_bin = 1'b1;
      psd_queue.insert(psd_queue.size(), r);
      fill_pos = 0;
      return;
    end
    for (int b = 0; b < HALF_BINS; b++) begin
      sum = db_sums[b];
      mag = (sum < 0) ? -sum : sum;
      mag = (mag + seg_total / 2) / seg_total;
      r = '0;
      r.bin_index = b[5:0];
      r.psd_db = (sum < 0) ? -longint'(mag) : longint'(mag);
      r.last_bin = (b == HALF_BINS - 1);
      psd_queue.insert(psd_queue.size(), r);
      db_sums[b] = 0;
    end
    seg_total = 0;
    fill_pos = 0;
  endfunction

  // Build the window and twiddle tables once
  initial begin
    longint unsigned t;
    errors = 0;
    for (int p = 0; p < FFT_SIZE; p++) begin
      t = ((longint'(p) << 24) + FFT_SIZE / 2) / FFT_SIZE;
      sin_tab[p] = turn_sine(t);
      cos_tab[p] = turn_sine((t + 64'h400000) & 64'hFFFFFF);
      hann_tab[p] = (32769 - cos_tab[p]) >>> 1;
    end
  end

  assign pending = psd_queue.size();

  // Watch all three channels at the clock edge
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      offset_db = DB_OFFSET_RESET;
      seg_total = 0;
      fill_pos = 0;
      foreach (db_sums[b]) db_sums[b] = 0;
      psd_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) offset_db = cfg_data;
      if (in_valid && !in_stall) take_sample(in_data);
      if (out_valid && !out_stall) begin
        if (psd_queue.size() == 0) begin
          $error("unexpected result bin_index=%0d", out_data.bin_index);
          errors++;
        end else begin
          want = psd_queue.pop_front();
          if (out_data.bin_index !== want.bin_index) begin
            $error("bin_index expected %0d actual %0d", want.bin_index, out_data.bin_index);
            errors++;
          end
          if (out_data.psd_db !== want.psd_db) begin
            $error("psd_db expected %0d actual %0d", want.psd_db, out_data.psd_db);
            errors++;
          end
          if (out_data.empty_run !== want.empty_run) begin
            $error("empty_run expected %0d actual %0d", want.empty_run,
                   out_data.empty_run);
            errors++;
          end
          if (out_data.last_bin !== want.last_bin) begin
            $error("last_bin expected %0d actual %0d", want.last_bin, out_data.last_bin);
            errors++;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/hann_window_psd_estimator_core_tb.sv
`timescale 1ns / 1ps
module hann_window_psd_estimator_core_tb;
  import hpsd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [14:0] cfg_data = '0;
  int   errors;
  int   pending;
  bit   calm = 1'b0;
  int   sent = 0;

  hann_window_psd_estimator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  hann_window_psd_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random backpressure on the result side
  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
  end

  // Offer one request and hold it until taken
  task automatic send(input logic signed [15:0] s, input logic eod);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.sample <= s;
    in_data.end_of_data <= eod;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // Let the block drain completely
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_offset(input logic [14:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample(input int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'sd0;
      2: return $signed(16'($urandom_range(6))) - 16'sd3;
      default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  // Whole segments of one content style each, then an optional trailing part
  task automatic send_record(input int segs, input int tail);
    int style;
    int total;
    total = segs * FFT_SIZE + tail;
    style = $urandom_range(3);
    for (int i = 0; i < total; i++) begin
      if (i % FFT_SIZE == 0) style = $urandom_range(3);
      send(pick_sample(style), i == total - 1);
    end
  endtask

  initial begin
    int rec;
    int segs;
    int tail;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty records and a partial segment with the extremes
    send(16'sh7FFF, 1'b1);
    send(16'sh7FFF, 1'b0);
    send(16'sh8000, 1'b0);
    send(16'sd0, 1'b0);
    send(16'sd1, 1'b0);
    send(-16'sd1, 1'b0);
    send(16'sh5555, 1'b0);
    send(16'shAAAA, 1'b1);
    drain();

    // A segment of random style with no offset, then a quiet segment at the largest offset
    write_offset(15'd0);
    send_record(1, 0);
    drain();
    write_offset(15'h7FFF);
    calm = 1'b1;
    for (int i = 0; i < FFT_SIZE; i++) send(16'sd0, 1'b0);
    for (int i = 0; i < 20; i++) send(pick_sample(2), i == 19);
    drain();
    calm = 1'b0;

    // Random records with random offsets
    rec = 0;
    while (sent < 370) begin
      write_offset(rec % 3 == 0 ? DB_OFFSET_RESET : 15'($urandom));
      segs = ($urandom_range(9) == 0) ? 0 : 1;
      tail = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 40);
      if (segs == 0 && tail == 0) tail = 1;
      send_record(segs, tail);
      drain();
      rec++;
    end

    if (errors == 0) begin
      $display("hann_window_psd_estimator_core test passed");
    end else begin
      $display("hann_window_psd_estimator_core test failed");
    end
    $finish;
  end

  // Hard stop on a hang
  initial begin
    #20000000;
    $display("hann_window_psd_estimator_core test failed");
    $finish;
  end

endmodule

>>> hann_window_psd_estimator_core.f
sv/hpsd_pkg.sv
sv/hpsd_div.sv
sv/hpsd_dp.sv
sv/hpsd_ctrl.sv
sv/hann_window_psd_estimator_core.sv
tb/sv/hann_window_psd_checker.sv
tb/sv/hann_window_psd_estimator_core_tb.sv
